@@ hw/rtl/csd_pkg.sv @@
// Shared types, widths and register codes for the capsule signed distance unit.
// Depends on nothing; every other file in hw/rtl imports it.
`timescale 1ns / 1ps
package csd_pkg;

    // Default number of fraction bits of the Q format.
    localparam int FRAC_BITS_DEF = 16;

    // Register file layout.
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_END_A_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_A_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_A_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_B_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_END_B_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END_B_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP_RADIUS = 3'd6;

    // Datapath widths.
    localparam int COORD_W = 32;
    localparam int RADIUS_W = 31;
    localparam int DIFF_W = 33;
    localparam int PROD_W = 66;
    localparam int DOT_W = 68;
    localparam int DD_W = 66;
    localparam int QUO_W = 32;
    localparam int SCALE_W = 65;
    localparam int E_W = 34;
    localparam int SQ_W = 68;
    localparam int ROOT_W = 34;
    localparam int ROOT_REM_W = 70;
    localparam int DIST_W = 36;

    typedef logic [2:0][COORD_W-1:0] t_coord3;
    typedef logic [2:0][DIFF_W-1:0] t_diff3;

    // How the projection parameter is chosen.
    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_ONE,
        MODE_FRAC
    } t_mode;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } t_point;

    typedef struct packed {
        logic signed [COORD_W-1:0] signed_distance;
        logic                      overflow;
    } t_result;

    // Projection state handed from the dot products through the divider.
    typedef struct packed {
        t_mode            mode;
        logic [DD_W-1:0]  rem;
        logic [DD_W-1:0]  dd;
        logic [QUO_W-1:0] quo;
        t_diff3           v;
    } t_proj;

endpackage

@@ hw/rtl/csd_front.sv @@
// Front end: point offsets, dot products and projection mode (four stages).
// Depends on csd_pkg.
`timescale 1ns / 1ps
module csd_front
    import csd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_vld,
    input  t_point  i_point,
    input  t_coord3 i_end_a,
    input  t_diff3  i_diff,
    output logic    o_vld,
    output t_proj   o_data
);

    logic [3:0] r_vld;
    t_coord3 w_p;
    t_diff3 r_v1, r_v2, r_v3;
    logic signed [2:0][PROD_W-1:0] r_dv, r_dd;
    logic signed [DOT_W-1:0] r_dot;
    logic [DD_W-1:0] r_ddsum;
    t_proj r_out;

    assign w_p[0] = i_point.point_x;
    assign w_p[1] = i_point.point_y;
    assign w_p[2] = i_point.point_z;

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    // Offsets, products, sums, then the mode decision.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_v1[i] <= DIFF_W'($signed(w_p[i])) - DIFF_W'($signed(i_end_a[i]));
                r_dv[i] <= PROD_W'($signed(i_diff[i]) * $signed(r_v1[i]));
                r_dd[i] <= PROD_W'($signed(i_diff[i]) * $signed(i_diff[i]));
            end
            r_v2 <= r_v1;
            r_dot <= DOT_W'($signed(r_dv[0])) + DOT_W'($signed(r_dv[1]))
                     + DOT_W'($signed(r_dv[2]));
            r_ddsum <= DD_W'(r_dd[0]) + DD_W'(r_dd[1]) + DD_W'(r_dd[2]);
            r_v3 <= r_v2;
            if (r_ddsum == '0 || r_dot <= 0) begin
                r_out.mode <= MODE_ZERO;
            end else if (r_dot >= $signed({2'b00, r_ddsum})) begin
                r_out.mode <= MODE_ONE;
            end else begin
                r_out.mode <= MODE_FRAC;
            end
            r_out.rem <= r_dot[DD_W-1:0];
            r_out.dd <= r_ddsum;
            r_out.quo <= '0;
            r_out.v <= r_v3;
        end
    end

    assign o_vld = r_vld[3];
    assign o_data = r_out;

endmodule

@@ hw/rtl/csd_divider.sv @@
// Restoring divider for the projection parameter, one quotient bit per stage.
// Depends on csd_pkg.
`timescale 1ns / 1ps
module csd_divider
    import csd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_vld,
    input  t_proj i_data,
    output logic  o_vld,
    output t_proj o_data
);

    logic [QUO_W-1:0] r_vld;
    t_proj r_stg [QUO_W];
    t_proj n_stg [QUO_W];

    // Each stage doubles the remainder and subtracts the divisor when it fits.
    always_comb begin
        t_proj src;
        logic [DD_W:0] dbl;
        for (int k = 0; k < QUO_W; k++) begin
            src = (k == 0) ? i_data : r_stg[(k == 0) ? 0 : k - 1];
            dbl = {src.rem, 1'b0};
            n_stg[k] = src;
            if (dbl >= {1'b0, src.dd}) begin
                n_stg[k].rem = DD_W'(dbl - {1'b0, src.dd});
                n_stg[k].quo = {src.quo[QUO_W-2:0], 1'b1};
            end else begin
                n_stg[k].rem = dbl[DD_W-1:0];
                n_stg[k].quo = {src.quo[QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[QUO_W-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QUO_W; k++) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    assign o_vld = r_vld[QUO_W-1];
    assign o_data = r_stg[QUO_W-1];

endmodule

@@ hw/rtl/csd_offset.sv @@
// Closest point offset and squared length (five stages).
// Depends on csd_pkg.
`timescale 1ns / 1ps
module csd_offset
    import csd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  t_proj                 i_data,
    input  t_diff3                i_diff,
    output logic                  o_vld,
    output logic [ROOT_REM_W-1:0] o_sum
);

    logic [4:0] r_vld;
    logic [2:0][SCALE_W-1:0] r_prod;
    t_mode r_mode;
    t_diff3 r_v1, r_v2;
    logic signed [2:0][E_W-1:0] r_td, r_e;
    logic [2:0][SQ_W-1:0] r_sq;
    logic [ROOT_REM_W-1:0] r_sum;
    logic [2:0][DIFF_W-1:0] w_mag;
    logic [2:0][E_W-1:0] w_round;

    // Magnitudes of the segment direction and the rounded t*|d|.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = i_diff[i][DIFF_W-1] ? DIFF_W'(-i_diff[i]) : i_diff[i];
            w_round[i] = E_W'((({1'b0, r_prod[i]}) + (66'(1) << (QUO_W - 1))) >> QUO_W);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    // Product, offset along the segment, offset, squares and their sum.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_prod[i] <= SCALE_W'(i_data.quo * w_mag[i]);
                case (r_mode)
                    MODE_ONE:  r_td[i] <= E_W'($signed(i_diff[i]));
                    MODE_FRAC: r_td[i] <= i_diff[i][DIFF_W-1] ? -w_round[i] : w_round[i];
                    default:   r_td[i] <= '0;
                endcase
                r_e[i] <= E_W'($signed(r_v2[i])) - r_td[i];
                r_sq[i] <= SQ_W'($signed(r_e[i]) * $signed(r_e[i]));
            end
            r_mode <= i_data.mode;
            r_v1 <= i_data.v;
            r_v2 <= r_v1;
            r_sum <= ROOT_REM_W'(r_sq[0]) + ROOT_REM_W'(r_sq[1]) + ROOT_REM_W'(r_sq[2]);
        end
    end

    assign o_vld = r_vld[4];
    assign o_sum = r_sum;

endmodule

@@ hw/rtl/csd_sqrt.sv @@
// Integer square root, one root bit per stage, then radius subtract and saturation.
// Depends on csd_pkg.
`timescale 1ns / 1ps
module csd_sqrt
    import csd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  logic [ROOT_REM_W-1:0] i_sum,
    input  logic [RADIUS_W-1:0]   i_radius,
    output logic                  o_vld,
    output t_result               o_result
);

    logic [ROOT_W:0] r_vld;
    logic [ROOT_REM_W-1:0] r_rem [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [ROOT_REM_W-1:0] n_rem [ROOT_W];
    logic [ROOT_W-1:0] n_root [ROOT_W];
    logic signed [DIST_W-1:0] w_dist;
    t_result r_out;

    // Stage k settles root bit ROOT_W-1-k against the running remainder.
    always_comb begin
        logic [ROOT_REM_W-1:0] src_rem;
        logic [ROOT_W-1:0] src_root;
        logic [ROOT_REM_W-1:0] trial;
        for (int k = 0; k < ROOT_W; k++) begin
            src_rem = (k == 0) ? i_sum : r_rem[(k == 0) ? 0 : k - 1];
            src_root = (k == 0) ? '0 : r_root[(k == 0) ? 0 : k - 1];
            trial = (ROOT_REM_W'(src_root) << (ROOT_W - k))
                    + (ROOT_REM_W'(1) << (2 * (ROOT_W - 1 - k)));
            n_rem[k] = src_rem;
            n_root[k] = src_root;
            if (src_rem >= trial) begin
                n_rem[k] = src_rem - trial;
                n_root[k] = src_root | (ROOT_W'(1) << (ROOT_W - 1 - k));
            end
        end
    end

    assign w_dist = $signed(DIST_W'(r_root[ROOT_W-1])) - $signed(DIST_W'(i_radius));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[ROOT_W-1:0], i_vld};
        end
    end

    // Root stages and the saturating output register.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < ROOT_W; k++) begin
                r_rem[k] <= n_rem[k];
                r_root[k] <= n_root[k];
            end
            if (w_dist > $signed(DIST_W'(32'h7fff_ffff))) begin
                r_out.signed_distance <= 32'h7fff_ffff;
                r_out.overflow <= 1'b1;
            end else if (w_dist < -$signed(DIST_W'(32'h8000_0000))) begin
                r_out.signed_distance <= 32'h8000_0000;
                r_out.overflow <= 1'b1;
            end else begin
                r_out.signed_distance <= w_dist[COORD_W-1:0];
                r_out.overflow <= 1'b0;
            end
        end
    end

    assign o_vld = r_vld[ROOT_W];
    assign o_result = r_out;

endmodule

@@ hw/rtl/capsule_signed_distance_unit.sv @@
// Capsule signed distance unit: top level with the register file and the pipeline.
// Depends on csd_pkg, csd_front, csd_divider, csd_offset and csd_sqrt.
//
// Usage: a query point transaction enters on i_valid / i_point and is taken at a
// rising edge where i_valid is high and o_stall is low. Each point yields one
// result transaction on o_valid / o_result, taken where o_valid is high and
// i_stall is low; results leave in the order the points came in.
// The stages are the dot products, 32 divider stages for the projection parameter,
// the offset and squared length, 34 square root stages and one saturating output
// register. One point is accepted per cycle while o_stall is low. The segment end
// points and radius are written through i_cfg_we, i_cfg_index and i_cfg_data; the user
// must write them only while the pipeline is empty, not enforced by the block; writes
// to unused indexes are ignored. Reset clears all valid bits and loads end A = 0,
// end B = (0, 1.0, 0), radius 1.0. While the receiver stalls a waiting result, the
// whole pipeline holds and o_stall is raised, so no transaction is lost or repeated.
`timescale 1ns / 1ps
module capsule_signed_distance_unit
    import csd_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_point                i_point,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_result               o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_coord3 r_end_a, r_end_b;
    logic [RADIUS_W-1:0] r_radius;
    t_diff3 w_diff;
    logic w_en;
    logic w_front_vld, w_div_vld, w_off_vld;
    t_proj w_front, w_div;
    logic [ROOT_REM_W-1:0] w_sum;

    // Register file writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_a <= '0;
            r_end_b[0] <= '0;
            r_end_b[1] <= COORD_W'(1) << FRAC_BITS;
            r_end_b[2] <= '0;
            r_radius <= RADIUS_W'(1) << FRAC_BITS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_END_A_X:    r_end_a[0] <= i_cfg_data;
                CFG_END_A_Y:    r_end_a[1] <= i_cfg_data;
                CFG_END_A_Z:    r_end_a[2] <= i_cfg_data;
                CFG_END_B_X:    r_end_b[0] <= i_cfg_data;
                CFG_END_B_Y:    r_end_b[1] <= i_cfg_data;
                CFG_END_B_Z:    r_end_b[2] <= i_cfg_data;
                CFG_CAP_RADIUS: r_radius <= i_cfg_data[RADIUS_W-1:0];
                default:        ;
            endcase
        end
    end

    // Segment direction, fixed between configuration writes.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_diff[i] = DIFF_W'($signed(r_end_b[i])) - DIFF_W'($signed(r_end_a[i]));
        end
    end

    // The pipeline advances unless a finished result is being held back.
    assign o_stall = o_valid & i_stall;
    assign w_en = ~o_stall;

    csd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_valid),
        .i_point (i_point),
        .i_end_a (r_end_a),
        .i_diff  (w_diff),
        .o_vld   (w_front_vld),
        .o_data  (w_front)
    );

    csd_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_front_vld),
        .i_data  (w_front),
        .o_vld   (w_div_vld),
        .o_data  (w_div)
    );

    csd_offset u_offset (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_div_vld),
        .i_data  (w_div),
        .i_diff  (w_diff),
        .o_vld   (w_off_vld),
        .o_sum   (w_sum)
    );

    csd_sqrt u_sqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_vld    (w_off_vld),
        .i_sum    (w_sum),
        .i_radius (r_radius),
        .o_vld    (o_valid),
        .o_result (o_result)
    );

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for capsule_signed_distance_unit.
// Depends on csd_pkg and the RTL of the unit. Results are predicted in plain SystemVerilog
// integer arithmetic and compared field by field with each result transaction.
`timescale 1ns / 1ps
module tb;
    import csd_pkg::*;

    localparam int CLK_PERIOD = 20;
    localparam int PIPE_LATENCY = 76;
    localparam int NUM_CFG = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam logic signed [31:0] Q_ONE = 32'sd65536;
    localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    t_point                i_point;
    logic                  o_valid;
    logic                  i_stall;
    t_result               o_result;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Shadow copy of the register file used by the distance predictor.
    logic signed [31:0] seg_end[6];
    logic [30:0]        radius_reg;

    t_result expected_results[$];
    int      mismatches;
    int      points_sent;
    int      results_seen;
    int      saturated_seen;
    int      sender_idle_pct;
    int      receiver_stall_pct;

    capsule_signed_distance_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_point    (i_point),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Hard limit on the run time.
    initial begin
        #(CLK_PERIOD * 400000);
        $display("CHECK FAILED");
        $finish;
    end

    // Signed distance from a point to the capsule held in the shadow registers.
    function automatic t_result capsule_distance(t_point p);
        logic signed [127:0] a, b, q, dot, dd, sq_sum, td, mw, gap;
        logic signed [127:0] d[3];
        logic signed [127:0] v[3];
        logic signed [127:0] e;
        logic [127:0]        root, cand;
        logic [63:0]         t_frac, mag, prod, m;
        logic signed [31:0]  pc[3];
        t_mode               mode;
        t_result             r;
        pc[0] = p.point_x;
        pc[1] = p.point_y;
        pc[2] = p.point_z;
        dot = 0;
        dd = 0;
        for (int i = 0; i < 3; i++) begin
            a = seg_end[i];
            b = seg_end[3 + i];
            q = pc[i];
            d[i] = b - a;
            v[i] = q - a;
            dot += d[i] * v[i];
            dd += d[i] * d[i];
        end
        // Clamp the projection parameter to the segment.
        t_frac = 0;
        if (dd == 0 || dot <= 0) begin
            mode = MODE_ZERO;
        end else if (dot >= dd) begin
            mode = MODE_ONE;
        end else begin
            mode = MODE_FRAC;
            t_frac = 64'((dot <<< 32) / dd);
        end
        sq_sum = 0;
        for (int i = 0; i < 3; i++) begin
            if (mode == MODE_ZERO) begin
                td = 0;
            end else if (mode == MODE_ONE) begin
                td = d[i];
            end else begin
                // Rounded product kept to 64 bits; the unit's product register is 65 bits wide.
                mag = 64'(d[i] < 0 ? -d[i] : d[i]);
                prod = t_frac * mag + 64'h8000_0000;
                m = prod >> 32;
                mw = {64'b0, m};
                td = d[i] < 0 ? -mw : mw;
            end
            e = v[i] - td;
            sq_sum += e * e;
        end
        // Integer square root, one bit at a time.
        root = 0;
        for (int bit_pos = 35; bit_pos >= 0; bit_pos--) begin
            cand = root | (128'd1 << bit_pos);
            if (cand * cand <= sq_sum) root = cand;
        end
        gap = $signed(root) - $signed({97'b0, radius_reg});
        r.overflow = 1'b0;
        if (gap > 128'sh7FFF_FFFF) begin
            r.signed_distance = COORD_MAX;
            r.overflow = 1'b1;
        end else if (gap < -128'sh8000_0000) begin
            r.signed_distance = COORD_MIN;
            r.overflow = 1'b1;
        end else begin
            r.signed_distance = gap[31:0];
        end
        return r;
    endfunction

    // Result checker and receiver stall generator.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $error("unexpected result transaction: %h", o_result);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (want.overflow) saturated_seen++;
                if (o_result.signed_distance !== want.signed_distance) begin
                    $error("signed_distance: expected %0d, got %0d",
                           want.signed_distance, o_result.signed_distance);
                    mismatches++;
                end
                if (o_result.overflow !== want.overflow) begin
                    $error("overflow: expected %0b, got %0b",
                           want.overflow, o_result.overflow);
                    mismatches++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // Send one point transaction and record its expected result on acceptance.
    task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y,
                              input logic signed [31:0] z);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_point <= '{point_x: x, point_y: y, point_z: z};
        do @(posedge i_clk); while (o_stall);
        expected_results.push_back(capsule_distance('{point_x: x, point_y: y, point_z: z}));
        points_sent++;
    endtask

    // Stop sending and wait until the pipeline has drained.
    task automatic drain;
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
    endtask

    // Register write; only called with the pipeline drained.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx < NUM_CFG) begin
            if (idx == CFG_CAP_RADIUS) radius_reg = data[30:0];
            else seg_end[idx] = data;
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_capsule(input logic signed [31:0] ax, input logic signed [31:0] ay,
                               input logic signed [31:0] az, input logic signed [31:0] bx,
                               input logic signed [31:0] by, input logic signed [31:0] bz,
                               input logic [30:0] rad);
        write_reg(CFG_END_A_X, ax);
        write_reg(CFG_END_A_Y, ay);
        write_reg(CFG_END_A_Z, az);
        write_reg(CFG_END_B_X, bx);
        write_reg(CFG_END_B_Y, by);
        write_reg(CFG_END_B_Z, bz);
        write_reg(CFG_CAP_RADIUS, {1'b0, rad});
    endtask

    function automatic logic signed [31:0] rand_coord(input int span_bits);
        logic signed [31:0] c;
        c = $urandom();
        if (span_bits < 32) c = c >>> (32 - span_bits);
        return c;
    endfunction

    // Reset values, then points before, beside and beyond the default segment.
    task automatic test_reset_capsule;
        send_point(0, 0, 0);
        send_point(0, Q_ONE, 0);
        send_point(0, -Q_ONE, 0);
        send_point(0, 32'sd3 * Q_ONE, 0);
        send_point(Q_ONE, Q_ONE / 2, 0);
        send_point(0, Q_ONE / 2, Q_ONE / 4);
        drain();
    endtask

    // Unused index write, degenerate segment, extreme coordinates, extreme radius and saturation.
    task automatic test_extremes;
        write_reg(CFG_UNUSED, 32'hDEAD_BEEF);
        set_capsule(Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 31'd0);
        send_point(Q_ONE, Q_ONE, Q_ONE);
        send_point(0, 0, 0);
        send_point(COORD_MAX, COORD_MIN, COORD_MAX);
        drain();
        set_capsule(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, 31'd0);
        send_point(COORD_MIN, COORD_MAX, COORD_MIN);
        send_point(COORD_MAX, COORD_MIN, COORD_MAX);
        send_point(0, 0, 0);
        send_point(32'sd12345, -32'sd999999, 32'sd77);
        send_point(COORD_MAX, COORD_MAX, COORD_MIN);
        drain();
        set_capsule(COORD_MAX, COORD_MIN, 0, COORD_MAX, COORD_MIN, 0, 31'h7FFF_FFFF);
        send_point(COORD_MIN, COORD_MAX, COORD_MIN);
        send_point(COORD_MAX, COORD_MIN, 0);
        send_point(0, 0, COORD_MAX);
        drain();
        set_capsule(-Q_ONE, 0, 0, Q_ONE, 0, 0, 31'h0000_8000);
        send_point(0, Q_ONE, 0);
        send_point(-32'sd5 * Q_ONE, 0, 0);
        send_point(32'sd5 * Q_ONE, 0, 0);
        send_point(Q_ONE / 3, -Q_ONE / 7, Q_ONE / 5);
        send_point(COORD_MIN, COORD_MIN, COORD_MIN);
        drain();
    endtask

    // Random capsules, each followed by a burst of random points.
    task automatic test_random_capsules(input int sender_pct, input int receiver_pct,
                                        input int num_points);
        int span, kind;
        logic signed [31:0] ax, ay, az, bx, by, bz;
        sender_idle_pct = sender_pct;
        receiver_stall_pct = receiver_pct;
        for (int n = 0; n < num_points; n++) begin
            if (n % 75 == 0) begin
                drain();
                kind = $urandom_range(9);
                span = kind == 0 ? 32 : $urandom_range(26, 18);
                ax = rand_coord(span);
                ay = rand_coord(span);
                az = rand_coord(span);
                if (kind == 1) begin
                    bx = ax;
                    by = ay;
                    bz = az;
                end else begin
                    bx = rand_coord(span);
                    by = rand_coord(span);
                    bz = rand_coord(span);
                end
                set_capsule(ax, ay, az, bx, by, bz,
                            kind == 2 ? 31'h7FFF_FFFF : 31'($urandom()) >> $urandom_range(30, 6));
            end
            case ($urandom_range(9))
                0: send_point($urandom(), $urandom(), $urandom());
                1: send_point(ax, ay, az);
                2: send_point(bx, by, bz);
                default: begin
                    span = $urandom_range(27, 16);
                    send_point(ax + rand_coord(span), ay + rand_coord(span),
                               az + rand_coord(span));
                end
            endcase
        end
        drain();
    endtask

    initial begin
        mismatches = 0;
        points_sent = 0;
        results_seen = 0;
        saturated_seen = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_point = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        for (int i = 0; i < 6; i++) seg_end[i] = 0;
        seg_end[CFG_END_B_Y] = Q_ONE;
        radius_reg = 31'(Q_ONE);
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_capsule();
        test_extremes();
        test_random_capsules(10, 51, 375);
        test_random_capsules(51, 10, 375);
        test_random_capsules(0, 0, 375);

        $display("Sent %0d points over directed and random capsules, %0d results checked.",
                 points_sent, results_seen);
        $display("%0d results saturated, %0d mismatches.", saturated_seen, mismatches);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/csd_pkg.sv
hw/rtl/csd_front.sv
hw/rtl/csd_divider.sv
hw/rtl/csd_offset.sv
hw/rtl/csd_sqrt.sv
hw/rtl/capsule_signed_distance_unit.sv
sim/tb.sv
